[hdl/tdf_pkg.sv]
// Package for the touch report decode filter.
// Holds codes, reset values and the structs; every other file imports it; no dependencies.

package tdf_pkg;

   // report framing
   localparam int unsigned REPORT_BYTES_DEFAULT = 15;
   localparam int unsigned POS_W                = 5;
   localparam logic [POS_W-1:0] POS_SAT         = 5'd31;
   localparam logic [7:0] ACK_VALUE             = 8'hAB;
   localparam logic [3:0] HEADER_VALUE          = 4'h6;

   // byte slots inside a report
   localparam logic [POS_W-1:0] POS_HEADER      = 5'd0;
   localparam logic [POS_W-1:0] POS_X_HIGH      = 5'd1;
   localparam logic [POS_W-1:0] POS_Y_HIGH      = 5'd2;
   localparam logic [POS_W-1:0] POS_LOW_NIBBLES = 5'd3;
   localparam logic [POS_W-1:0] POS_POINT_COUNT = 5'd5;
   localparam logic [POS_W-1:0] POS_ACK         = 5'd6;

   // field widths
   localparam int unsigned COORD_W  = 12;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] DEBOUNCE_RESET     = 16'd120;
   localparam logic [15:0] REPEAT_RESET       = 16'd600;
   localparam logic [7:0]  NEAR_RESET         = 8'd8;
   localparam logic [COORD_W-1:0] SCREEN_RESET = 12'd465;

   // register index map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_REPEAT       = 2'd1,
      CSR_NEAR         = 2'd2,
      CSR_SCREEN_LIMIT = 2'd3
   } csr_index_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_ACCEPT     = 3'd0,
      ST_BAD_LENGTH = 3'd1,
      ST_NO_ACK     = 3'd2,
      ST_NO_POINT   = 3'd3,
      ST_BAD_HEADER = 3'd4,
      ST_DEBOUNCED  = 3'd5,
      ST_REPEAT     = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0]        debounce_ms;
      logic [15:0]        repeat_ms;
      logic [7:0]         near_radius;
      logic [COORD_W-1:0] screen_limit;
   } cfg_type;

   // report bytes as seen at the current word, current byte merged in
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [3:0]       header_nibble;
      logic [7:0]       x_high_byte;
      logic [7:0]       y_high_byte;
      logic [7:0]       low_nibbles_byte;
      logic [7:0]       point_count_byte;
      logic [7:0]       ack_byte;
   } view_type;

   typedef struct packed {
      status_type         status;
      logic [COORD_W-1:0] raw_x;
      logic [COORD_W-1:0] raw_y;
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
   } result_type;

endpackage

[hdl/tdf_if.sv]
// Handshake channels of the touch report decode filter: report bytes in, results out.
// Depends on tdf_pkg for field widths.

interface tdf_req_if import tdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [7:0]        rx_byte;
   logic              end_of_report;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, rx_byte, end_of_report, now_ms, input ready);
   modport sink   (input valid, rx_byte, end_of_report, now_ms, output ready);
endinterface

interface tdf_rsp_if import tdf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [COORD_W-1:0] raw_x;
   logic [COORD_W-1:0] raw_y;
   logic [COORD_W-1:0] screen_x;
   logic [COORD_W-1:0] screen_y;

   modport source (output valid, status, raw_x, raw_y, screen_x, screen_y, input ready);
   modport sink   (input valid, status, raw_x, raw_y, screen_x, screen_y, output ready);
endinterface

[hdl/tdf_byte_store.sv]
// Byte position counter and report byte store of the touch report decode filter.
// Depends on tdf_pkg; the view it gives already includes the byte being stepped.

module tdf_byte_store import tdf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       end_of_report,
   output view_type   view
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       header_ff;
   logic [7:0]       x_high_ff, y_high_ff, low_ff, count_ff, ack_ff;

   // merge current byte over the stored slot it lands in
   always_comb begin
      view.position         = pos_ff;
      view.header_nibble    = (pos_ff == POS_HEADER)      ? rx_byte[3:0] : header_ff;
      view.x_high_byte      = (pos_ff == POS_X_HIGH)      ? rx_byte      : x_high_ff;
      view.y_high_byte      = (pos_ff == POS_Y_HIGH)      ? rx_byte      : y_high_ff;
      view.low_nibbles_byte = (pos_ff == POS_LOW_NIBBLES) ? rx_byte      : low_ff;
      view.point_count_byte = (pos_ff == POS_POINT_COUNT) ? rx_byte      : count_ff;
      view.ack_byte         = (pos_ff == POS_ACK)         ? rx_byte      : ack_ff;
   end

   // next position: back to zero after the end byte, else saturating count
   always_comb begin
      if (end_of_report) begin
         pos_in = '0;
      end else if (pos_ff == POS_SAT) begin
         pos_in = pos_ff;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   // slot store; every slot is rewritten before a well-formed report reads it
   always_ff @(posedge clock) begin
      if (step) begin
         header_ff <= view.header_nibble;
         x_high_ff <= view.x_high_byte;
         y_high_ff <= view.y_high_byte;
         low_ff    <= view.low_nibbles_byte;
         count_ff  <= view.point_count_byte;
         ack_ff    <= view.ack_byte;
      end
   end

endmodule

[hdl/tdf_touch_filter.sv]
// Report checks, coordinate build, clamp and mirror, debounce and repeat windows.
// Depends on tdf_pkg; holds the last accepted point and time.

module tdf_touch_filter import tdf_pkg::*; #(
   parameter int unsigned REPORT_BYTES = REPORT_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  view_type          view,
   input  logic [TIME_W-1:0] now_ms,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_BYTES - 1);

   logic [TIME_W-1:0]  last_time_ff;
   logic [COORD_W-1:0] last_x_ff, last_y_ff;

   logic [COORD_W-1:0] rx, ry, sx, sy, dist_x, dist_y;
   logic [TIME_W-1:0]  dt;
   logic               near, in_debounce, in_repeat;

   // coordinates and mirrored screen position
   always_comb begin
      rx = {view.x_high_byte, view.low_nibbles_byte[7:4]};
      ry = {view.y_high_byte, view.low_nibbles_byte[3:0]};
      sx = cfg.screen_limit - ((rx < cfg.screen_limit) ? rx : cfg.screen_limit);
      sy = cfg.screen_limit - ((ry < cfg.screen_limit) ? ry : cfg.screen_limit);
      dist_x = (sx >= last_x_ff) ? (sx - last_x_ff) : (last_x_ff - sx);
      dist_y = (sy >= last_y_ff) ? (sy - last_y_ff) : (last_y_ff - sy);
      near = (dist_x <= COORD_W'(cfg.near_radius)) && (dist_y <= COORD_W'(cfg.near_radius));
      dt = now_ms - last_time_ff;
      in_debounce = dt < TIME_W'(cfg.debounce_ms);
      in_repeat   = dt < TIME_W'(cfg.repeat_ms);
   end

   // checks in priority order; reports failing a framing check carry zero coordinates
   always_comb begin
      result = '{status: ST_ACCEPT, raw_x: '0, raw_y: '0, screen_x: '0, screen_y: '0};
      if (view.position != LAST_POS) begin
         result.status = ST_BAD_LENGTH;
      end else if (view.ack_byte != ACK_VALUE) begin
         result.status = ST_NO_ACK;
      end else if (view.point_count_byte[6:0] == 7'd0) begin
         result.status = ST_NO_POINT;
      end else if (view.header_nibble != HEADER_VALUE) begin
         result.status = ST_BAD_HEADER;
      end else begin
         result.raw_x    = rx;
         result.raw_y    = ry;
         result.screen_x = sx;
         result.screen_y = sy;
         if (in_debounce) begin
            result.status = ST_DEBOUNCED;
         end else if (near && in_repeat) begin
            result.status = ST_REPEAT;
         end
      end
   end

   // last accepted touch
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
      end else if (step && (result.status == ST_ACCEPT)) begin
         last_time_ff <= now_ms;
         last_x_ff    <= sx;
         last_y_ff    <= sy;
      end
   end

endmodule

[hdl/touch_report_decode_filter.sv]
// Top level of the touch report decode filter: input register, config registers,
// result register. Depends on tdf_pkg, tdf_if, tdf_byte_store and tdf_touch_filter.
//
//   channel  direction  handshake            word
//   req      in         valid/ready          rx_byte, end_of_report, now_ms
//   rsp      out        valid/ready          status, raw_x, raw_y, screen_x, screen_y
//   csr      in         csr_we, no response  csr_index, csr_wdata
//
// One word is taken per cycle unless an end word is stalled; a result enters the result register
// as its end word leaves the input register; an accepted report also updates the last point and time.
// Reset is synchronous and clears the byte position, the last point and time and the
// registers to their defaults. A waiting result stalls input only when the word in the
// input register is an end word; other words keep flowing.

module touch_report_decode_filter import tdf_pkg::*; #(
   parameter int unsigned REPORT_BYTES = REPORT_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   tdf_req_if.sink               req,
   tdf_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff;
   logic              s1_vld_ff, s1_last_ff;
   logic [7:0]        s1_byte_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              rsp_vld_ff;
   result_type        rsp_ff;
   logic              advance;
   view_type          view;
   result_type        result;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{debounce_ms: DEBOUNCE_RESET, repeat_ms: REPEAT_RESET,
                     near_radius: NEAR_RESET, screen_limit: SCREEN_RESET};
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:     cfg_ff.debounce_ms  <= csr_wdata;
            CSR_REPEAT:       cfg_ff.repeat_ms    <= csr_wdata;
            CSR_NEAR:         cfg_ff.near_radius  <= csr_wdata[7:0];
            CSR_SCREEN_LIMIT: cfg_ff.screen_limit <= csr_wdata[COORD_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // word moves on unless it is an end word and the result register is held
   assign advance   = s1_vld_ff && (!s1_last_ff || !rsp_vld_ff || rsp.ready);
   assign req.ready = !s1_vld_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff <= req.rx_byte;
         s1_last_ff <= req.end_of_report;
         s1_now_ff  <= req.now_ms;
      end
   end

   tdf_byte_store u_store (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .rx_byte       (s1_byte_ff),
      .end_of_report (s1_last_ff),
      .view          (view)
   );

   tdf_touch_filter #(
      .REPORT_BYTES (REPORT_BYTES)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .step   (advance && s1_last_ff),
      .view   (view),
      .now_ms (s1_now_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && s1_last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid    = rsp_vld_ff;
   assign rsp.status   = rsp_ff.status;
   assign rsp.raw_x    = rsp_ff.raw_x;
   assign rsp.raw_y    = rsp_ff.raw_y;
   assign rsp.screen_x = rsp_ff.screen_x;
   assign rsp.screen_y = rsp_ff.screen_y;

   // a new result only ever follows an end word in the input register
   a_result_from_end_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_vld_ff && s1_last_ff))
      else $error("result without an end word");

   // a held result must block an end word from overwriting it
   a_end_word_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_last_ff && rsp_vld_ff && !rsp.ready) |-> !req.ready)
      else $error("end word not stalled behind held result");

   // reports failing a framing check carry no coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_ff.status == ST_BAD_LENGTH || rsp_ff.status == ST_NO_ACK ||
                      rsp_ff.status == ST_NO_POINT || rsp_ff.status == ST_BAD_HEADER))
      |-> (rsp_ff.raw_x == '0 && rsp_ff.raw_y == '0 &&
           rsp_ff.screen_x == '0 && rsp_ff.screen_y == '0))
      else $error("rejected report with coordinates");

endmodule
